// ----- hdl/i2cm_pkg.sv -----
// ----------------------------------------------------------------------------
// i2cm_pkg
// Types and codes shared by the I2C register master and its bus engine.
// ----------------------------------------------------------------------------
package i2cm_pkg;

    // Configuration register indexes
    localparam logic [1:0] CFG_HALF_PERIOD = 2'd0;
    localparam logic [1:0] CFG_SETTLE      = 2'd1;

    localparam logic [7:0]  HALF_PERIOD_RESET = 8'd30;
    localparam logic [19:0] SETTLE_RESET      = 20'd5000;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_BUS_BUSY  = 2'd1,
        STAT_BUS_ERROR = 2'd2,
        STAT_ADDR_NACK = 2'd3
    } status_t;

    typedef enum logic [4:0] {
        PH_IDLE    = 5'd0,
        PH_ST_A    = 5'd1,
        PH_ST_B    = 5'd2,
        PH_ST_C    = 5'd3,
        PH_TX_LOW  = 5'd4,
        PH_TX_DATA = 5'd5,
        PH_TX_HIGH = 5'd6,
        PH_WA_LOW  = 5'd7,
        PH_WA_REL  = 5'd8,
        PH_WA_HIGH = 5'd9,
        PH_WA_END  = 5'd10,
        PH_RX_LOW  = 5'd11,
        PH_RX_HIGH = 5'd12,
        PH_MA_LOW  = 5'd13,
        PH_MA_DATA = 5'd14,
        PH_MA_HIGH = 5'd15,
        PH_MA_END  = 5'd16,
        PH_SP_A    = 5'd17,
        PH_SP_B    = 5'd18,
        PH_SP_C    = 5'd19,
        PH_SP_D    = 5'd20,
        PH_SETTLE  = 5'd21,
        PH_RS_A    = 5'd22,
        PH_RS_B    = 5'd23,
        PH_RS_C    = 5'd24
    } phase_t;

    typedef struct packed {
        logic       scl;
        logic       sda;
        logic       busy;
        logic       byte_valid;
        logic [7:0] read_byte;
        logic [3:0] byte_index;
        logic       done;
        status_t    status;
    } result_t;

endpackage

// ----- hdl/i2cm_engine.sv -----
// ----------------------------------------------------------------------------
// i2cm_engine
// Bus sequencer: one tick per step, drives SCL/SDA levels and reports status.
// ----------------------------------------------------------------------------
module i2cm_engine #(
    parameter int MAX_READ_BYTES = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic              kind,
    input  logic              op_read,
    input  logic [6:0]        dev_addr,
    input  logic [7:0]        reg_addr,
    input  logic [7:0]        write_data,
    input  logic [4:0]        read_count,
    input  logic              sda_in,
    input  logic [7:0]        half_period,
    input  logic [19:0]       settle_ticks,
    output i2cm_pkg::result_t res
);
    import i2cm_pkg::*;

    localparam int CNT_LOG = $clog2(MAX_READ_BYTES + 1);
    localparam int CNT_W   = (MAX_READ_BYTES >= 31) ? 5 : ((CNT_LOG < 2) ? 2 : CNT_LOG);

    phase_t             phase_reg, phase_next;
    logic [7:0]         tick_reg, tick_next;
    logic [19:0]        settle_reg, settle_next;
    logic [2:0]         bit_reg, bit_next;
    logic [CNT_W-1:0]   bytes_reg, bytes_next;
    logic [7:0]         shift_reg, shift_next;
    logic               rq_read_reg, rq_read_next;
    logic [6:0]         rq_dev_reg, rq_dev_next;
    logic [7:0]         rq_reg_reg, rq_reg_next;
    logic [7:0]         rq_data_reg, rq_data_next;
    logic [CNT_W-1:0]   rq_count_reg, rq_count_next;
    logic               scl_reg, scl_next;
    logic               sda_reg, sda_next;
    status_t            pend_reg, pend_next;

    logic               go;        // enter phase_next with its pin levels
    logic               fin;       // transaction ends this tick
    logic [CNT_W-1:0]   count_sat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_IDLE;
            tick_reg     <= '0;
            settle_reg   <= '0;
            bit_reg      <= '0;
            bytes_reg    <= '0;
            shift_reg    <= '0;
            rq_read_reg  <= 1'b0;
            rq_dev_reg   <= '0;
            rq_reg_reg   <= '0;
            rq_data_reg  <= '0;
            rq_count_reg <= '0;
            scl_reg      <= 1'b1;
            sda_reg      <= 1'b1;
            pend_reg     <= STAT_OK;
        end
        else if (step)
        begin
            phase_reg    <= phase_next;
            tick_reg     <= tick_next;
            settle_reg   <= settle_next;
            bit_reg      <= bit_next;
            bytes_reg    <= bytes_next;
            shift_reg    <= shift_next;
            rq_read_reg  <= rq_read_next;
            rq_dev_reg   <= rq_dev_next;
            rq_reg_reg   <= rq_reg_next;
            rq_data_reg  <= rq_data_next;
            rq_count_reg <= rq_count_next;
            scl_reg      <= scl_next;
            sda_reg      <= sda_next;
            pend_reg     <= pend_next;
        end
    end

    // read count clamped to 1..MAX_READ_BYTES
    always_comb
    begin
        if (read_count == 5'd0)
            count_sat = CNT_W'(1);
        else if (int'(read_count) > MAX_READ_BYTES)
            count_sat = CNT_W'(MAX_READ_BYTES);
        else
            count_sat = CNT_W'(read_count);
    end

    always_comb
    begin
        phase_next    = phase_reg;
        tick_next     = tick_reg;
        settle_next   = settle_reg;
        bit_next      = bit_reg;
        bytes_next    = bytes_reg;
        shift_next    = shift_reg;
        rq_read_next  = rq_read_reg;
        rq_dev_next   = rq_dev_reg;
        rq_reg_next   = rq_reg_reg;
        rq_data_next  = rq_data_reg;
        rq_count_next = rq_count_reg;
        scl_next      = scl_reg;
        sda_next      = sda_reg;
        pend_next     = pend_reg;
        go            = 1'b0;
        fin           = 1'b0;
        res           = '0;

        if (phase_reg == PH_IDLE)
        begin
            if (kind)
            begin
                rq_read_next  = op_read;
                rq_dev_next   = dev_addr;
                rq_reg_next   = reg_addr;
                rq_data_next  = write_data;
                rq_count_next = count_sat;
                pend_next     = STAT_OK;
                bytes_next    = '0;
                bit_next      = '0;
                shift_next    = '0;
                phase_next    = PH_ST_A;
                go            = 1'b1;
            end
        end
        else if (phase_reg == PH_SETTLE)
        begin
            if (({1'b0, settle_reg} + 21'd1) >= {1'b0, settle_ticks})
                fin = 1'b1;
            else
                settle_next = settle_reg + 20'd1;
        end
        else if (({1'b0, tick_reg} + 9'd1) < {1'b0, half_period})
        begin
            tick_next = tick_reg + 8'd1;
        end
        else
        begin
            go = 1'b1;
            case (phase_reg)
                PH_ST_A:
                begin
                    if (!sda_in)
                    begin
                        pend_next = STAT_BUS_BUSY;
                        fin       = 1'b1;
                    end
                    else
                        phase_next = PH_ST_B;
                end
                PH_ST_B:
                begin
                    if (sda_in)
                    begin
                        pend_next = STAT_BUS_ERROR;
                        fin       = 1'b1;
                    end
                    else
                        phase_next = PH_ST_C;
                end
                PH_ST_C:
                begin
                    shift_next = {rq_dev_reg, 1'b0};
                    bit_next   = '0;
                    bytes_next = '0;
                    phase_next = PH_TX_LOW;
                end
                PH_TX_LOW:  phase_next = PH_TX_DATA;
                PH_TX_DATA: phase_next = PH_TX_HIGH;
                PH_TX_HIGH:
                begin
                    shift_next = {shift_reg[6:0], 1'b0};
                    bit_next   = bit_reg + 3'd1;
                    phase_next = (bit_reg == 3'd7) ? PH_WA_LOW : PH_TX_LOW;
                end
                PH_WA_LOW: phase_next = PH_WA_REL;
                PH_WA_REL: phase_next = PH_WA_HIGH;
                PH_WA_HIGH:
                begin
                    // only the first address byte is checked for ACK
                    if (bytes_reg == '0 && sda_in)
                        pend_next = STAT_ADDR_NACK;
                    phase_next = PH_WA_END;
                end
                PH_WA_END:
                begin
                    if (bytes_reg == CNT_W'(0))
                    begin
                        if (pend_reg == STAT_ADDR_NACK)
                            phase_next = PH_SP_A;
                        else
                        begin
                            shift_next = rq_reg_reg;
                            bit_next   = '0;
                            bytes_next = CNT_W'(1);
                            phase_next = PH_TX_LOW;
                        end
                    end
                    else if (bytes_reg == CNT_W'(1))
                    begin
                        if (rq_read_reg)
                            phase_next = PH_RS_A;
                        else
                        begin
                            shift_next = rq_data_reg;
                            bit_next   = '0;
                            bytes_next = CNT_W'(2);
                            phase_next = PH_TX_LOW;
                        end
                    end
                    else if (rq_read_reg)
                    begin
                        bytes_next = '0;
                        bit_next   = '0;
                        shift_next = '0;
                        phase_next = PH_RX_LOW;
                    end
                    else
                        phase_next = PH_SP_A;
                end
                PH_RX_LOW: phase_next = PH_RX_HIGH;
                PH_RX_HIGH:
                begin
                    shift_next = {shift_reg[6:0], sda_in};
                    bit_next   = bit_reg + 3'd1;
                    if (bit_reg == 3'd7)
                    begin
                        res.byte_valid = 1'b1;
                        res.read_byte  = shift_next;
                        res.byte_index = 4'(bytes_reg);
                        bytes_next     = bytes_reg + CNT_W'(1);
                        phase_next     = PH_MA_LOW;
                    end
                    else
                        phase_next = PH_RX_LOW;
                end
                PH_MA_LOW:  phase_next = PH_MA_DATA;
                PH_MA_DATA: phase_next = PH_MA_HIGH;
                PH_MA_HIGH: phase_next = PH_MA_END;
                PH_MA_END:
                begin
                    if (bytes_reg >= rq_count_reg)
                        phase_next = PH_SP_A;
                    else
                    begin
                        bit_next   = '0;
                        shift_next = '0;
                        phase_next = PH_RX_LOW;
                    end
                end
                PH_SP_A: phase_next = PH_SP_B;
                PH_SP_B: phase_next = PH_SP_C;
                PH_SP_C: phase_next = PH_SP_D;
                PH_SP_D:
                begin
                    if (pend_reg == STAT_OK && !rq_read_reg && settle_ticks != 20'd0)
                    begin
                        settle_next = '0;
                        phase_next  = PH_SETTLE;
                    end
                    else
                        fin = 1'b1;
                end
                PH_RS_A: phase_next = PH_RS_B;
                PH_RS_B: phase_next = PH_RS_C;
                PH_RS_C:
                begin
                    shift_next = {rq_dev_reg, 1'b1};
                    bit_next   = '0;
                    bytes_next = CNT_W'(2);
                    phase_next = PH_TX_LOW;
                end
                default: fin = 1'b1;
            endcase
        end

        if (fin)
        begin
            phase_next = PH_IDLE;
            tick_next  = '0;
            scl_next   = 1'b1;
            sda_next   = 1'b1;
            res.done   = 1'b1;
            res.status = pend_next;
        end
        else if (go)
        begin
            tick_next = '0;
            case (phase_next)
                PH_ST_A, PH_RS_A, PH_SP_D, PH_SETTLE, PH_WA_HIGH, PH_RX_HIGH:
                begin
                    scl_next = 1'b1;
                    sda_next = 1'b1;
                end
                PH_ST_B, PH_ST_C, PH_RS_B, PH_RS_C, PH_SP_C:
                begin
                    scl_next = 1'b1;
                    sda_next = 1'b0;
                end
                PH_TX_LOW, PH_WA_LOW, PH_MA_LOW, PH_SP_A, PH_MA_END:
                    scl_next = 1'b0;
                PH_TX_DATA:
                begin
                    scl_next = 1'b0;
                    sda_next = shift_next[7];
                end
                PH_TX_HIGH, PH_MA_HIGH:
                    scl_next = 1'b1;
                PH_WA_REL, PH_WA_END, PH_RX_LOW:
                begin
                    scl_next = 1'b0;
                    sda_next = 1'b1;
                end
                PH_MA_DATA:
                begin
                    // NACK the last byte, ACK the others
                    scl_next = 1'b0;
                    sda_next = (bytes_next >= rq_count_next);
                end
                PH_SP_B:
                begin
                    scl_next = 1'b0;
                    sda_next = 1'b0;
                end
                default: ;
            endcase
        end

        res.scl  = scl_next;
        res.sda  = sda_next;
        res.busy = (phase_next != PH_IDLE);
    end

endmodule

// ----- hdl/i2c_register_master.sv -----
// ----------------------------------------------------------------------------
// i2c_register_master
// Bit-banged I2C master for single register writes and multi-byte reads.
// ----------------------------------------------------------------------------
// Usage:
//   Each request on the input channel (in_valid / in_stall) is one bus tick.
//   kind=1 on an idle tick starts a transaction from op_read, dev_addr,
//   reg_addr, write_data and read_count; kind is ignored while busy.
//   sda_in is the sampled SDA level for that tick.
//   Every accepted request yields exactly one result on the output channel
//   (out_valid / out_stall): pin drives, busy, a received byte strobe and a
//   done strobe with status (ok, bus busy, bus error, address NACK).
//   Results are registered before out_valid; one request can be taken
//   every cycle while the skid entry is free. The bus engine updates in
//   a single pass per tick, so the output register sets the pace.
//   An output register plus one skid entry decouple the sides: while the
//   receiver stalls, one more request is taken, then in_stall rises until
//   the output moves again. Nothing is lost or reordered.
//   The user must write configuration (cfg_we / cfg_index / cfg_data)
//   only while idle; the block does not enforce it. Index 0 half period
//   ticks, index 1 write settle ticks; others ignored. Reset: engine
//   idle, both lines released, registers at 30 and 5000, no result pending.
// ----------------------------------------------------------------------------
module i2c_register_master #(
    parameter int MAX_READ_BYTES = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    // configuration write port
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [19:0] cfg_data,
    // tick request channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        kind,
    input  logic        op_read,
    input  logic [6:0]  dev_addr,
    input  logic [7:0]  reg_addr,
    input  logic [7:0]  write_data,
    input  logic [4:0]  read_count,
    input  logic        sda_in,
    // result channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic        scl_out,
    output logic        sda_out,
    output logic        busy_res,
    output logic        byte_valid,
    output logic [7:0]  read_byte,
    output logic [3:0]  byte_index,
    output logic        done_res,
    output logic [1:0]  status
);
    import i2cm_pkg::*;

    logic [7:0]  half_period_reg;
    logic [19:0] settle_ticks_reg;

    logic        in_take;
    logic        out_load;
    result_t     eng_res;

    logic        out_valid_reg, out_valid_next;
    logic        skid_valid_reg, skid_valid_next;
    result_t     out_data_reg;
    result_t     skid_data_reg;

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_period_reg  <= HALF_PERIOD_RESET;
            settle_ticks_reg <= SETTLE_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_HALF_PERIOD: half_period_reg  <= cfg_data[7:0];
                CFG_SETTLE:      settle_ticks_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // a request is taken whenever the skid entry is free
    assign in_take  = in_valid && !skid_valid_reg;
    assign in_stall = skid_valid_reg;

    i2cm_engine #(
        .MAX_READ_BYTES(MAX_READ_BYTES)
    ) u_engine (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (in_take),
        .kind         (kind),
        .op_read      (op_read),
        .dev_addr     (dev_addr),
        .reg_addr     (reg_addr),
        .write_data   (write_data),
        .read_count   (read_count),
        .sda_in       (sda_in),
        .half_period  (half_period_reg),
        .settle_ticks (settle_ticks_reg),
        .res          (eng_res)
    );

    // output register can load when empty or being drained
    assign out_load = !out_valid_reg || !out_stall;

    always_comb
    begin
        if (out_load)
        begin
            out_valid_next  = skid_valid_reg || in_take;
            skid_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next  = 1'b1;
            skid_valid_next = skid_valid_reg || in_take;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            if (skid_valid_reg)
                out_data_reg <= skid_data_reg;
            else if (in_take)
                out_data_reg <= eng_res;
        end
        else if (in_take)
            skid_data_reg <= eng_res;
    end

    assign out_valid  = out_valid_reg;
    assign scl_out    = out_data_reg.scl;
    assign sda_out    = out_data_reg.sda;
    assign busy_res   = out_data_reg.busy;
    assign byte_valid = out_data_reg.byte_valid;
    assign read_byte  = out_data_reg.read_byte;
    assign byte_index = out_data_reg.byte_index;
    assign done_res   = out_data_reg.done;
    assign status     = out_data_reg.status;

endmodule
